// File: rtl/core/dllc_pkg.sv
// Package for the doubly linked list cursor engine.
// Holds the command codes and the fixed field widths; no dependencies.
package dllc_pkg;

  localparam int CmdW = 5;
  localparam int DataW = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR      = 5'd0,
    CMD_INS_FIRST  = 5'd1,
    CMD_INS_LAST   = 5'd2,
    CMD_CUR_FIRST  = 5'd3,
    CMD_CUR_LAST   = 5'd4,
    CMD_GET_FIRST  = 5'd5,
    CMD_GET_LAST   = 5'd6,
    CMD_DEL_FIRST  = 5'd7,
    CMD_DEL_LAST   = 5'd8,
    CMD_DEL_AFTER  = 5'd9,
    CMD_DEL_BEFORE = 5'd10,
    CMD_INS_AFTER  = 5'd11,
    CMD_INS_BEFORE = 5'd12,
    CMD_GET_CUR    = 5'd13,
    CMD_SET_CUR    = 5'd14,
    CMD_NEXT       = 5'd15,
    CMD_PREV       = 5'd16,
    CMD_QUERY      = 5'd17
  } cmd_e;

endpackage

// File: rtl/core/doubly_linked_list_cursor_engine_top.sv
// Doubly linked list with cursor: top level, node pool in flip-flops.
// Depends on dllc_pkg (command codes, field widths).
//
// A request enters the input register when it is not stalled; from there the list
// operation runs in a single combinational pass over the node pool and head,
// tail, cursor and free pointers, and the response lands in the output
// register; the block sustains one request per cycle while the output side
// keeps up. A waiting response stalls only the input register. The free
// chain is loaded by reset, so there is no clearing pass; clear returns the
// whole list to the free chain at once. Pointer value POOL_NODES means null.
module doubly_linked_list_cursor_engine_top
  import dllc_pkg::*;
#(
  parameter int POOL_NODES  = 16,
  parameter int VALUE_WIDTH = 32,
  localparam int PW = $clog2(POOL_NODES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CmdW-1:0]   command_i,
  input  logic [DataW-1:0]  value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DataW-1:0]  read_value_o,
  output logic              error_o,
  output logic              cursor_valid_o,
  output logic [PW-1:0]     length_o
);

  localparam int IW = $clog2(POOL_NODES);
  localparam logic [PW-1:0] NIL = PW'(POOL_NODES);

  // node pool
  logic [PW-1:0]          node_next_q [POOL_NODES];
  logic [PW-1:0]          node_prev_q [POOL_NODES];
  logic [VALUE_WIDTH-1:0] node_value_q [POOL_NODES];

  logic [PW-1:0] head_q, head_d, tail_q, tail_d, cur_q, cur_d;
  logic [PW-1:0] free_q, free_d, cnt_q, cnt_d;

  // request and response registers
  logic             req_vld_q, req_vld_d;
  logic [CmdW-1:0]  req_cmd_q;
  logic [DataW-1:0] req_val_q;
  logic             rsp_vld_q, rsp_vld_d;
  logic [DataW-1:0] rsp_rv_q;
  logic             rsp_err_q, rsp_cv_q;
  logic [PW-1:0]    rsp_len_q;

  logic fire, accept;

  // write ports
  logic                   wn0_en, wn1_en, wp0_en, wp1_en, wv_en;
  logic [PW-1:0]          wn0_a, wn0_d, wn1_a, wn1_d;
  logic [PW-1:0]          wp0_a, wp0_d, wp1_a, wp1_d;
  logic [PW-1:0]          wv_a;
  logic [VALUE_WIDTH-1:0] wv_d, vin;

  logic [PW-1:0]  free_nx, head_nx, tail_pv, cur_nx, cur_pv, cur_nx2, cur_pv2;
  logic [PW-1:0]  rd_ptr;
  logic           rd_en, err, full;
  logic [DataW-1:0] rv;

  function automatic logic [PW-1:0] nx(logic [PW-1:0] p);
    if (p == NIL) return NIL;
    return node_next_q[p[IW-1:0]];
  endfunction

  function automatic logic [PW-1:0] pv(logic [PW-1:0] p);
    if (p == NIL) return NIL;
    return node_prev_q[p[IW-1:0]];
  endfunction

  function automatic logic [DataW-1:0] sext(logic [VALUE_WIDTH-1:0] v);
    logic signed [63:0] e;
    e = 64'($signed(v));
    return e[DataW-1:0];
  endfunction

  assign fire       = req_vld_q && (!rsp_vld_q || !out_stall_i);
  assign in_stall_o = req_vld_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  assign full    = (free_q == NIL);
  assign vin     = VALUE_WIDTH'({32'd0, req_val_q});

  // link lookups; always_comb so link table updates are seen
  always_comb begin
    free_nx = nx(free_q);
    head_nx = nx(head_q);
    tail_pv = pv(tail_q);
    cur_nx  = nx(cur_q);
    cur_pv  = pv(cur_q);
    cur_nx2 = nx(cur_nx);
    cur_pv2 = pv(cur_pv);
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cur_d  = cur_q;
    free_d = free_q;
    cnt_d  = cnt_q;
    wn0_en = 1'b0; wn0_a = NIL; wn0_d = NIL;
    wn1_en = 1'b0; wn1_a = NIL; wn1_d = NIL;
    wp0_en = 1'b0; wp0_a = NIL; wp0_d = NIL;
    wp1_en = 1'b0; wp1_a = NIL; wp1_d = NIL;
    wv_en  = 1'b0; wv_a  = NIL; wv_d  = vin;
    rd_en  = 1'b0;
    rd_ptr = NIL;
    err    = 1'b0;
    case (req_cmd_q)
      CMD_CLEAR: begin
        if (head_q != NIL) begin
          wn0_en = 1'b1; wn0_a = tail_q; wn0_d = free_q;
          free_d = head_q;
        end
        head_d = NIL;
        tail_d = NIL;
        cur_d  = NIL;
        cnt_d  = '0;
      end
      CMD_INS_FIRST: begin
        if (full) begin
          err = 1'b1;
        end else begin
          free_d = free_nx; cnt_d = cnt_q + 1'b1;
          wv_en  = 1'b1; wv_a = free_q;
          wp0_en = 1'b1; wp0_a = free_q; wp0_d = NIL;
          wn0_en = 1'b1; wn0_a = free_q; wn0_d = head_q;
          if (head_q == NIL) begin
            tail_d = free_q;
          end else begin
            wp1_en = 1'b1; wp1_a = head_q; wp1_d = free_q;
          end
          head_d = free_q;
        end
      end
      CMD_INS_LAST: begin
        if (full) begin
          err = 1'b1;
        end else begin
          free_d = free_nx; cnt_d = cnt_q + 1'b1;
          wv_en  = 1'b1; wv_a = free_q;
          wn0_en = 1'b1; wn0_a = free_q; wn0_d = NIL;
          wp0_en = 1'b1; wp0_a = free_q; wp0_d = tail_q;
          if (tail_q == NIL) begin
            head_d = free_q;
          end else begin
            wn1_en = 1'b1; wn1_a = tail_q; wn1_d = free_q;
          end
          tail_d = free_q;
        end
      end
      CMD_CUR_FIRST: cur_d = head_q;
      CMD_CUR_LAST:  cur_d = tail_q;
      CMD_GET_FIRST: begin
        if (head_q == NIL) err = 1'b1;
        else begin rd_en = 1'b1; rd_ptr = head_q; end
      end
      CMD_GET_LAST: begin
        if (tail_q == NIL) err = 1'b1;
        else begin rd_en = 1'b1; rd_ptr = tail_q; end
      end
      CMD_DEL_FIRST: begin
        if (head_q != NIL) begin
          head_d = head_nx;
          if (head_nx != NIL) begin
            wp0_en = 1'b1; wp0_a = head_nx; wp0_d = NIL;
          end else begin
            tail_d = NIL;
          end
          if (cur_q == head_q) cur_d = NIL;
          wn1_en = 1'b1; wn1_a = head_q; wn1_d = free_q;
          free_d = head_q;
          if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
        end
      end
      CMD_DEL_LAST: begin
        if (tail_q != NIL) begin
          tail_d = tail_pv;
          if (tail_pv != NIL) begin
            wn0_en = 1'b1; wn0_a = tail_pv; wn0_d = NIL;
          end else begin
            head_d = NIL;
          end
          if (cur_q == tail_q) cur_d = NIL;
          wn1_en = 1'b1; wn1_a = tail_q; wn1_d = free_q;
          free_d = tail_q;
          if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
        end
      end
      CMD_DEL_AFTER: begin
        if (cur_q != NIL && cur_nx != NIL) begin
          wn0_en = 1'b1; wn0_a = cur_q; wn0_d = cur_nx2;
          if (cur_nx2 != NIL) begin
            wp0_en = 1'b1; wp0_a = cur_nx2; wp0_d = cur_q;
          end else begin
            tail_d = cur_q;
          end
          wn1_en = 1'b1; wn1_a = cur_nx; wn1_d = free_q;
          free_d = cur_nx;
          if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
        end
      end
      CMD_DEL_BEFORE: begin
        if (cur_q != NIL && cur_pv != NIL) begin
          wp0_en = 1'b1; wp0_a = cur_q; wp0_d = cur_pv2;
          if (cur_pv2 != NIL) begin
            wn0_en = 1'b1; wn0_a = cur_pv2; wn0_d = cur_q;
          end else begin
            head_d = cur_q;
          end
          wn1_en = 1'b1; wn1_a = cur_pv; wn1_d = free_q;
          free_d = cur_pv;
          if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
        end
      end
      CMD_INS_AFTER: begin
        if (cur_q != NIL) begin
          if (full) begin
            err = 1'b1;
          end else begin
            free_d = free_nx; cnt_d = cnt_q + 1'b1;
            wv_en  = 1'b1; wv_a = free_q;
            wn0_en = 1'b1; wn0_a = free_q; wn0_d = cur_nx;
            wp0_en = 1'b1; wp0_a = free_q; wp0_d = cur_q;
            wn1_en = 1'b1; wn1_a = cur_q;  wn1_d = free_q;
            if (cur_nx != NIL) begin
              wp1_en = 1'b1; wp1_a = cur_nx; wp1_d = free_q;
            end else begin
              tail_d = free_q;
            end
          end
        end
      end
      CMD_INS_BEFORE: begin
        if (cur_q != NIL) begin
          if (full) begin
            err = 1'b1;
          end else begin
            free_d = free_nx; cnt_d = cnt_q + 1'b1;
            wv_en  = 1'b1; wv_a = free_q;
            wn0_en = 1'b1; wn0_a = free_q; wn0_d = cur_q;
            wp0_en = 1'b1; wp0_a = free_q; wp0_d = cur_pv;
            if (cur_pv == NIL) begin
              head_d = free_q;
            end else begin
              wn1_en = 1'b1; wn1_a = cur_pv; wn1_d = free_q;
            end
            wp1_en = 1'b1; wp1_a = cur_q; wp1_d = free_q;
          end
        end
      end
      CMD_GET_CUR: begin
        if (cur_q == NIL) err = 1'b1;
        else begin rd_en = 1'b1; rd_ptr = cur_q; end
      end
      CMD_SET_CUR: begin
        if (cur_q != NIL) begin
          wv_en = 1'b1; wv_a = cur_q;
        end
      end
      CMD_NEXT: cur_d = cur_nx;
      CMD_PREV: cur_d = cur_pv;
      default: ;
    endcase
  end

  always_comb begin
    rv = '0;
    if (rd_en) rv = sext(node_value_q[rd_ptr[IW-1:0]]);
  end

  always_comb begin
    req_vld_d = req_vld_q;
    if (accept) req_vld_d = 1'b1;
    else if (fire) req_vld_d = 1'b0;
    rsp_vld_d = rsp_vld_q;
    if (fire) rsp_vld_d = 1'b1;
    else if (!out_stall_i) rsp_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
      head_q    <= NIL;
      tail_q    <= NIL;
      cur_q     <= NIL;
      free_q    <= '0;
      cnt_q     <= '0;
    end else begin
      req_vld_q <= req_vld_d;
      rsp_vld_q <= rsp_vld_d;
      if (fire) begin
        head_q <= head_d;
        tail_q <= tail_d;
        cur_q  <= cur_d;
        free_q <= free_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_cmd_q <= command_i;
      req_val_q <= value_i;
    end
    if (fire) begin
      rsp_rv_q  <= rv;
      rsp_err_q <= err;
      rsp_cv_q  <= (cur_d != NIL);
      rsp_len_q <= cnt_d;
    end
  end

  // next links: reset loads the free chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < POOL_NODES; i++) node_next_q[i] <= PW'(i + 1);
    end else if (fire) begin
      for (int i = 0; i < POOL_NODES; i++) begin
        if (wn1_en && wn1_a[IW-1:0] == IW'(i)) node_next_q[i] <= wn1_d;
        else if (wn0_en && wn0_a[IW-1:0] == IW'(i)) node_next_q[i] <= wn0_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int i = 0; i < POOL_NODES; i++) begin
        if (wp1_en && wp1_a[IW-1:0] == IW'(i)) node_prev_q[i] <= wp1_d;
        else if (wp0_en && wp0_a[IW-1:0] == IW'(i)) node_prev_q[i] <= wp0_d;
      end
      if (wv_en) node_value_q[wv_a[IW-1:0]] <= wv_d;
    end
  end

  assign out_valid_o    = rsp_vld_q;
  assign read_value_o   = rsp_rv_q;
  assign error_o        = rsp_err_q;
  assign cursor_valid_o = rsp_cv_q;
  assign length_o       = rsp_len_q;

endmodule

// File: rtl/core/dllc_checker.sv
// Port-level checks for the doubly linked list cursor engine, bound to the top.
// Depends on dllc_pkg and doubly_linked_list_cursor_engine_top.
module dllc_checker
  import dllc_pkg::*;
#(
  parameter int POOL_NODES = 16,
  localparam int PW = $clog2(POOL_NODES + 1)
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [CmdW-1:0]  command_i,
  input logic [DataW-1:0] value_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [DataW-1:0] read_value_o,
  input logic             error_o,
  input logic             cursor_valid_o,
  input logic [PW-1:0]    length_o
);

  // empty list cannot hold a cursor
  a_empty_no_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && length_o == '0 |-> !cursor_valid_o)
    else $error("cursor valid on empty list");

  // failed request reads nothing
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> read_value_o == '0)
    else $error("nonzero read value with error");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> length_o <= PW'(POOL_NODES))
    else $error("length above pool size");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_value_o)
      && $stable(error_o) && $stable(cursor_valid_o) && $stable(length_o))
    else $error("stalled response changed");

endmodule

bind doubly_linked_list_cursor_engine_top dllc_checker #(
  .POOL_NODES(POOL_NODES)
) u_dllc_checker (.*);
